FILE: sv/lcsf_pkg.sv
// ---------------------------------------------------------------------------
// lcsf_pkg
// Shared codes, defaults and controller/datapath interface types for the
// longest common substring finder.
// ---------------------------------------------------------------------------
package lcsf_pkg;

  // Default store capacities
  localparam int unsigned DEF_MAX_LEN_A = 256;
  localparam int unsigned DEF_MAX_LEN_B = 256;

  // Input item kinds (carried in s_tuser)
  localparam logic [1:0] ACT_LOAD_A  = 2'd0;
  localparam logic [1:0] ACT_LOAD_B  = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_COMPLEXITY_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATIENCE_ROWS    = 1'd1;

  localparam logic [16:0] COMPLEXITY_LIMIT_RST = 17'd65536;
  localparam logic [7:0]  PATIENCE_ROWS_RST    = 8'd100;

  // Result field width
  localparam int unsigned RES_W = 9;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic suf_init;
    logic suf_rd;
    logic suf_inc;
    logic tab_init;
    logic row_rd;
    logic row_ld;
    logic col_step;
    logic row_end;
    logic finish;
  } lcsf_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic empty;
    logic over_limit;
    logic suf_eq;
    logic suf_last;
    logic row_last;
    logic stop_scan;
    logic out_free;
  } lcsf_status_t;

endpackage

FILE: sv/longest_common_substring_finder_unit.sv
// ---------------------------------------------------------------------------
// longest_common_substring_finder_unit
// Longest common substring of two byte strings, found by a one-row dynamic
// programming scan, with a common-suffix fallback above a size limit.
// ---------------------------------------------------------------------------
// Load items (append to A or B) complete in the accept cycle and can follow back to back.
// A compute item holds s_tready low while it scans the table row by row in table mode,
// or compares byte pairs in suffix mode; the result shows on m_tvalid at the edge where
// s_tready returns, and a result still waiting holds the last cycle.
// Reset clears the string lengths, drop flag and the output valid and restores the config defaults;
// the string stores are not swept, so the block is ready right after reset.
module longest_common_substring_finder_unit import lcsf_pkg::*; #(
  parameter int unsigned MAX_LEN_A = DEF_MAX_LEN_A,
  parameter int unsigned MAX_LEN_B = DEF_MAX_LEN_B
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] byte_value
  input  logic [1:0]            s_tuser,   // [1:0] action
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // [8:0] match_length, [17:9] start_in_a,
                                           // [26:18] start_in_b, [31:27] zero
  output logic [1:0]            m_tuser,   // [0] suffix_mode, [1] overflowed
  // Configuration writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  lcsf_cmd_t         cmd;
  lcsf_status_t      status;
  logic [RES_W-1:0]  res_len;
  logic [RES_W-1:0]  res_start_a;
  logic [RES_W-1:0]  res_start_b;
  logic              res_suffix;
  logic              res_ovf;

  // Sequencer: accepts items only while idle; loads complete in the accept cycle
  lcsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .action   (s_tuser),
    .status   (status),
    .cmd      (cmd),
    .in_ready (s_tready)
  );

  // Stores, row table, match tracking and the output register
  lcsf_dpath #(
    .MAX_LEN_A (MAX_LEN_A),
    .MAX_LEN_B (MAX_LEN_B)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .byte_value  (s_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_len     (res_len),
    .out_start_a (res_start_a),
    .out_start_b (res_start_b),
    .out_suffix  (res_suffix),
    .out_ovf     (res_ovf)
  );

  // Pack the result item
  assign m_tdata = {5'd0, res_start_b, res_start_a, res_len};
  assign m_tuser = {res_ovf, res_suffix};

endmodule

FILE: sv/lcsf_ram.sv
// ---------------------------------------------------------------------------
// lcsf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lcsf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/lcsf_ctrl.sv
// ---------------------------------------------------------------------------
// lcsf_ctrl
// Sequencer: takes input items, walks the suffix compare or the table scan
// and hands the result to the output register.
// ---------------------------------------------------------------------------
module lcsf_ctrl import lcsf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [1:0]   action,
  input  lcsf_status_t status,
  output lcsf_cmd_t    cmd,
  output logic         in_ready
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SUF_RD,
    ST_SUF_CMP,
    ST_ROW_RD,
    ST_ROW_LD,
    ST_CELL,
    ST_ROW_END,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_LOAD_A: cmd.load_a = 1'b1;
            ACT_LOAD_B: cmd.load_b = 1'b1;
            ACT_COMPUTE: begin
              cmd.start  = 1'b1;
              state_next = ST_DECIDE;
            end
            default: ;
          endcase
        end
      end
      ST_DECIDE: begin
        if (status.empty) begin
          state_next = ST_DONE;
        end else if (status.over_limit) begin
          cmd.suf_init = 1'b1;
          state_next   = ST_SUF_RD;
        end else begin
          cmd.tab_init = 1'b1;
          state_next   = ST_ROW_RD;
        end
      end
      ST_SUF_RD: begin
        cmd.suf_rd = 1'b1;
        state_next = ST_SUF_CMP;
      end
      ST_SUF_CMP: begin
        if (status.suf_eq) begin
          cmd.suf_inc = 1'b1;
          state_next  = status.suf_last ? ST_DONE : ST_SUF_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_ROW_RD: begin
        cmd.row_rd = 1'b1;
        state_next = ST_ROW_LD;
      end
      ST_ROW_LD: begin
        cmd.row_ld = 1'b1;
        state_next = ST_CELL;
      end
      ST_CELL: begin
        cmd.col_step = 1'b1;
        if (status.row_last) begin
          state_next = ST_ROW_END;
        end
      end
      ST_ROW_END: begin
        cmd.row_end = 1'b1;
        state_next  = status.stop_scan ? ST_DONE : ST_ROW_RD;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == ST_IDLE);
    end
  end

endmodule

FILE: sv/lcsf_dpath.sv
// ---------------------------------------------------------------------------
// lcsf_dpath
// String stores, one-row match table, counters, best-match tracking,
// configuration registers and the output register.
// ---------------------------------------------------------------------------
module lcsf_dpath import lcsf_pkg::*; #(
  parameter int unsigned MAX_LEN_A = DEF_MAX_LEN_A,
  parameter int unsigned MAX_LEN_B = DEF_MAX_LEN_B
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lcsf_cmd_t             cmd,
  output lcsf_status_t          status,
  input  logic [7:0]            byte_value,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RES_W-1:0]      out_len,
  output logic [RES_W-1:0]      out_start_a,
  output logic [RES_W-1:0]      out_start_b,
  output logic                  out_suffix,
  output logic                  out_ovf
);

  localparam int unsigned CA_W   = $clog2(MAX_LEN_A + 1);
  localparam int unsigned CB_W   = $clog2(MAX_LEN_B + 1);
  localparam int unsigned AA_W   = (MAX_LEN_A > 1) ? $clog2(MAX_LEN_A) : 1;
  localparam int unsigned AB_W   = (MAX_LEN_B > 1) ? $clog2(MAX_LEN_B) : 1;
  localparam int unsigned LEN_W  = (CA_W > CB_W) ? CA_W : CB_W;
  localparam int unsigned PROD_W = CA_W + CB_W;

  // Control state
  logic [CA_W-1:0]   count_a;
  logic [CB_W-1:0]   count_b;
  logic              drop_flag;
  logic [16:0]       complexity_limit;
  logic [7:0]        patience_rows;

  // Working registers
  logic [PROD_W-1:0] product;
  logic              suffix;
  logic [LEN_W-1:0]  n;
  logic [LEN_W-1:0]  best;
  logic [AA_W-1:0]   end_a;
  logic [AB_W-1:0]   end_b;
  logic [AA_W-1:0]   row_i;
  logic [AB_W-1:0]   col_j;
  logic [7:0]        a_row;
  logic [LEN_W-1:0]  diag;
  logic              row_first;
  logic              improved;
  logic [8:0]        idle;

  // RAM ports
  logic [7:0]        rdata_a;
  logic [7:0]        rdata_b;
  logic [LEN_W-1:0]  rdata_r;
  logic [AA_W-1:0]   raddr_a;
  logic [AB_W-1:0]   raddr_b;
  logic [AB_W-1:0]   raddr_r;
  logic              we_a;
  logic              we_b;

  // Combinational helpers
  logic [CA_W-1:0]   suf_addr_a;
  logic [CB_W-1:0]   suf_addr_b;
  logic [AB_W-1:0]   col_nxt;
  logic [LEN_W-1:0]  old_len;
  logic              cell_eq;
  logic [LEN_W-1:0]  cell_len;
  logic [8:0]        idle_next;
  logic [31:0]       res_len;
  logic [31:0]       res_sa;
  logic [31:0]       res_sb;

  assign we_a = cmd.load_a && (count_a < CA_W'(MAX_LEN_A));
  assign we_b = cmd.load_b && (count_b < CB_W'(MAX_LEN_B));

  assign suf_addr_a = count_a - CA_W'(1) - CA_W'(n);
  assign suf_addr_b = count_b - CB_W'(1) - CB_W'(n);
  assign col_nxt    = cmd.row_ld ? '0 : col_j + AB_W'(1);

  assign raddr_a = cmd.row_rd ? row_i : suf_addr_a[AA_W-1:0];
  assign raddr_b = cmd.suf_rd ? suf_addr_b[AB_W-1:0] : col_nxt;
  assign raddr_r = col_nxt;

  lcsf_ram #(.WIDTH(8), .DEPTH(MAX_LEN_A)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a[AA_W-1:0]),
    .wdata (byte_value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  lcsf_ram #(.WIDTH(8), .DEPTH(MAX_LEN_B)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b[AB_W-1:0]),
    .wdata (byte_value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // Previous row of match lengths, overwritten column by column
  lcsf_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN_B)) u_row (
    .clk   (clk),
    .we    (cmd.col_step),
    .waddr (col_j),
    .wdata (cell_len),
    .raddr (raddr_r),
    .rdata (rdata_r)
  );

  // Table cell: first row sees an all-zero previous row
  assign old_len  = row_first ? '0 : rdata_r;
  assign cell_eq  = (a_row == rdata_b);
  assign cell_len = cell_eq ? diag + LEN_W'(1) : '0;

  assign idle_next = (improved ? 9'd0 : idle) + 9'd1;

  always_comb begin
    res_len = suffix ? 32'(n) : 32'(best);
    if (res_len == 32'd0) begin
      res_sa = '0;
      res_sb = '0;
    end else if (suffix) begin
      res_sa = 32'(count_a) - 32'(n);
      res_sb = 32'(count_b) - 32'(n);
    end else begin
      res_sa = 32'(end_a) + 32'd1 - 32'(best);
      res_sb = 32'(end_b) + 32'd1 - 32'(best);
    end
  end

  assign status.empty      = (count_a == '0) || (count_b == '0);
  assign status.over_limit = 32'(product) > 32'(complexity_limit);
  assign status.suf_eq     = (rdata_a == rdata_b);
  assign status.suf_last   = (32'(n) + 32'd1 >= 32'(count_a)) ||
                             (32'(n) + 32'd1 >= 32'(count_b));
  assign status.row_last   = (32'(col_j) + 32'd1 == 32'(count_b));
  assign status.stop_scan  = (idle_next > {1'b0, patience_rows}) ||
                             (32'(row_i) + 32'd1 == 32'(count_a));
  assign status.out_free   = !out_valid || out_ready;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_a          <= '0;
      count_b          <= '0;
      drop_flag        <= 1'b0;
      out_valid        <= 1'b0;
      complexity_limit <= COMPLEXITY_LIMIT_RST;
      patience_rows    <= PATIENCE_ROWS_RST;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_COMPLEXITY_LIMIT: complexity_limit <= cfg_data[16:0];
          REG_PATIENCE_ROWS:    patience_rows    <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.load_a) begin
        if (we_a) begin
          count_a <= count_a + CA_W'(1);
        end else begin
          drop_flag <= 1'b1;
        end
      end
      if (cmd.load_b) begin
        if (we_b) begin
          count_b <= count_b + CB_W'(1);
        end else begin
          drop_flag <= 1'b1;
        end
      end
      if (cmd.finish) begin
        count_a   <= '0;
        count_b   <= '0;
        drop_flag <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      product <= PROD_W'(count_a) * PROD_W'(count_b);
      suffix  <= 1'b0;
      n       <= '0;
      best    <= '0;
    end
    if (cmd.suf_init) begin
      suffix <= 1'b1;
    end
    if (cmd.suf_inc) begin
      n <= n + LEN_W'(1);
    end
    if (cmd.tab_init) begin
      row_i     <= '0;
      row_first <= 1'b1;
      idle      <= '0;
    end
    if (cmd.row_ld) begin
      a_row    <= rdata_a;
      col_j    <= '0;
      diag     <= '0;
      improved <= 1'b0;
    end
    if (cmd.col_step) begin
      diag  <= old_len;
      col_j <= col_j + AB_W'(1);
      if (cell_eq && (cell_len > best)) begin
        best     <= cell_len;
        end_a    <= row_i;
        end_b    <= col_j;
        improved <= 1'b1;
      end
    end
    if (cmd.row_end) begin
      idle      <= idle_next;
      row_i     <= row_i + AA_W'(1);
      row_first <= 1'b0;
    end
    if (cmd.finish) begin
      out_len     <= res_len[RES_W-1:0];
      out_start_a <= res_sa[RES_W-1:0];
      out_start_b <= res_sb[RES_W-1:0];
      out_suffix  <= suffix;
      out_ovf     <= drop_flag;
    end
  end

endmodule

FILE: sim/longest_common_substring_finder_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// longest_common_substring_finder_unit_tb
// Streams load and compute items into the substring finder and checks every
// match result against a predictor kept inside the bench, under several
// limit and patience settings and with random stalls on both streams.
// ---------------------------------------------------------------------------
module longest_common_substring_finder_unit_tb import lcsf_pkg::*; ();

  localparam int unsigned MAX_A = DEF_MAX_LEN_A;
  localparam int unsigned MAX_B = DEF_MAX_LEN_B;
  // Action code 3 has no meaning; the block must ignore it
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Quiet time after the last result before touching the registers or ending
  localparam int unsigned SETTLE_CYCLES = 16;
  // Worst case is one full 256-row scan plus stalls; allow well beyond that
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] value;
  } load_item_t;

  typedef struct packed {
    logic [8:0] length;
    logic [8:0] start_a;
    logic [8:0] start_b;
    logic       suffix;
    logic       dropped;
  } match_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;    // [7:0] byte_value
  logic [1:0]            s_tuser = '0;    // [1:0] action
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;         // [8:0] length, [17:9] start A, [26:18] start B
  logic [1:0]            m_tuser;         // [0] suffix_mode, [1] overflowed
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  longest_common_substring_finder_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Items waiting for the input stream, and matches waiting for the output
  load_item_t  pending_items [$];
  load_item_t  head_item;
  match_t      expected_matches [$];

  // Mirror of the block state: strings, lengths, drop flag and registers
  logic [7:0]  str_a [0:MAX_A-1];
  logic [7:0]  str_b [0:MAX_B-1];
  int unsigned len_a = 0;
  int unsigned len_b = 0;
  bit          drop_seen = 1'b0;
  logic [16:0] limit_q = COMPLEXITY_LIMIT_RST;
  logic [7:0]  patience_q = PATIENCE_ROWS_RST;

  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  bit          in_took = 1'b0;
  int unsigned pushed_count = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned n_table = 0;
  int unsigned n_suffix = 0;
  int unsigned n_empty = 0;
  int unsigned n_dropped = 0;

  // -------------------------------------------------------------------------
  // Predictor: apply one accepted item and queue the match it produces.
  // -------------------------------------------------------------------------
  function automatic void step_model(input logic [1:0] act, input logic [7:0] val);
    match_t      res;
    int unsigned prev_row [0:MAX_B];
    int unsigned cur_row [0:MAX_B];
    int unsigned best, end_a, end_b, idle_rows, run, sa, sb, i, j;
    bit          via_suffix, stop_scan;
    res = '0;
    best = 0;
    end_a = 0;
    end_b = 0;
    idle_rows = 0;
    sa = 0;
    sb = 0;
    via_suffix = 1'b0;
    stop_scan = 1'b0;
    case (act)
      ACT_LOAD_A: begin
        // Drop and flag bytes beyond capacity
        if (len_a < MAX_A) begin
          str_a[len_a] = val;
          len_a++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      ACT_LOAD_B: begin
        if (len_b < MAX_B) begin
          str_b[len_b] = val;
          len_b++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      ACT_COMPUTE: begin
        if (len_a != 0 && len_b != 0) begin
          if (len_a * len_b > limit_q) begin
            // Too big for the scan: measure the common tail only
            via_suffix = 1'b1;
            while (best < len_a && best < len_b &&
                   str_a[len_a - 1 - best] == str_b[len_b - 1 - best])
              best++;
            sa = len_a - best;
            sb = len_b - best;
          end else begin
            for (j = 0; j <= MAX_B; j++) begin
              prev_row[j] = 0;
              cur_row[j] = 0;
            end
            // Row-major walk; strict > keeps the first of equal-length matches
            for (i = 0; i < len_a && !stop_scan; i++) begin
              for (j = 0; j < len_b; j++) begin
                if (str_a[i] != str_b[j]) begin
                  cur_row[j + 1] = 0;
                end else begin
                  run = prev_row[j] + 1;
                  cur_row[j + 1] = run;
                  if (run > best) begin
                    idle_rows = 0;
                    best = run;
                    end_a = i;
                    end_b = j;
                  end
                end
              end
              idle_rows++;
              // Give up once more than patience rows bring nothing new
              stop_scan = (idle_rows > patience_q);
              for (j = 0; j <= len_b; j++)
                prev_row[j] = cur_row[j];
            end
            if (best != 0) begin
              sa = end_a + 1 - best;
              sb = end_b + 1 - best;
            end
          end
          // No match at all reports both starts as zero
          if (best == 0) begin
            sa = 0;
            sb = 0;
          end
        end
        res.length  = best[8:0];
        res.start_a = sa[8:0];
        res.start_b = sb[8:0];
        res.suffix  = via_suffix;
        res.dropped = drop_seen;
        expected_matches.push_back(res);
        if (via_suffix)
          n_suffix++;
        else if (len_a == 0 || len_b == 0)
          n_empty++;
        else
          n_table++;
        if (drop_seen)
          n_dropped++;
        // Compute clears both strings and the drop flag
        len_a = 0;
        len_b = 0;
        drop_seen = 1'b0;
      end
      default: begin
        // Unused action code: no state change, no result
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [8:0] want,
                                        input logic [8:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Input acceptance and result checking, both on the rising edge.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    in_took <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      step_model(s_tuser, s_tdata);
      accepted_count++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_matches.size() == 0) begin
        $display("%0t ns: result with none expected, expected nothing, actual len %0d",
                 $time, m_tdata[8:0]);
        error_count++;
      end else begin
        compare_field("match_length", expected_matches[0].length, m_tdata[8:0]);
        compare_field("start_in_a", expected_matches[0].start_a, m_tdata[17:9]);
        compare_field("start_in_b", expected_matches[0].start_b, m_tdata[26:18]);
        compare_field("suffix_mode", {8'd0, expected_matches[0].suffix}, {8'd0, m_tuser[0]});
        compare_field("overflowed", {8'd0, expected_matches[0].dropped}, {8'd0, m_tuser[1]});
        void'(expected_matches.pop_front());
      end
      checked_count++;
    end
  end

  // Hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_matches.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Driver: hold the item until taken, then advance or idle at random.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_took) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        head_item = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= head_item.action;
        s_tdata  <= head_item.value;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic push_item(input logic [1:0] act, input logic [7:0] val);
    load_item_t it;
    it.action = act;
    it.value  = val;
    pending_items.push_back(it);
    pushed_count++;
  endtask

  // Wait until every item is taken and every match has come, then settle
  task automatic wait_idle();
    do
      @(negedge clk);
    while (accepted_count != pushed_count || expected_matches.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_COMPLEXITY_LIMIT)
      limit_q = val[16:0];
    else
      patience_q = val[7:0];
  endtask

  // Mostly short strings, now and then empty or a bit longer
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 8);
    else
      return $urandom_range(9, 24);
  endfunction

  // One random job: a well-formed pair of strings and a compute most of the
  // time, otherwise unused codes or a stray run of loads with no compute
  task automatic queue_job();
    logic [7:0]  a_txt [0:31];
    logic [7:0]  b_txt [0:31];
    logic [7:0]  base, mask;
    int unsigned roll, na, nb, ia, ib, k, span, pa, pb;
    roll = $urandom_range(0, 99);
    if (roll < 78) begin
      na = pick_len();
      nb = pick_len();
      base = 8'($urandom);
      // Narrow alphabets make matches likely; the full byte range covers all bits
      case ($urandom_range(0, 3))
        0:       mask = 8'h01;
        1:       mask = 8'h03;
        2:       mask = 8'h0F;
        default: mask = 8'hFF;
      endcase
      for (k = 0; k < na; k++)
        a_txt[k] = base ^ (8'($urandom) & mask);
      for (k = 0; k < nb; k++)
        b_txt[k] = base ^ (8'($urandom) & mask);
      // Plant a shared run of A inside B half of the time
      if (na > 0 && nb > 0 && $urandom_range(0, 1) == 1) begin
        span = $urandom_range(1, (na < nb) ? na : nb);
        pa = $urandom_range(0, na - span);
        pb = $urandom_range(0, nb - span);
        for (k = 0; k < span; k++)
          b_txt[pb + k] = a_txt[pa + k];
      end
      ia = 0;
      ib = 0;
      while (ia < na || ib < nb) begin
        if ($urandom_range(0, 29) == 0)
          push_item(ACT_UNUSED, 8'($urandom));
        if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
          push_item(ACT_LOAD_A, a_txt[ia]);
          ia++;
        end else begin
          push_item(ACT_LOAD_B, b_txt[ib]);
          ib++;
        end
      end
      push_item(ACT_COMPUTE, 8'($urandom));
    end else if (roll < 90) begin
      span = $urandom_range(1, 3);
      for (k = 0; k < span; k++)
        push_item(ACT_UNUSED, 8'($urandom));
      if ($urandom_range(0, 1) == 1)
        push_item(ACT_COMPUTE, 8'($urandom));
    end else begin
      span = $urandom_range(1, 6);
      for (k = 0; k < span; k++)
        push_item($urandom_range(0, 1) ? ACT_LOAD_B : ACT_LOAD_A, 8'($urandom));
    end
  endtask

  // Long strings from a four-letter alphabet; lengths past capacity overflow
  task automatic queue_long_run(input int unsigned na, input int unsigned nb);
    int unsigned k;
    for (k = 0; k < na; k++)
      push_item(ACT_LOAD_A, 8'h30 ^ (8'($urandom) & 8'h03));
    for (k = 0; k < nb; k++)
      push_item(ACT_LOAD_B, 8'h30 ^ (8'($urandom) & 8'h03));
    push_item(ACT_COMPUTE, 8'h00);
  endtask

  task automatic queue_directed();
    // Both strings empty
    push_item(ACT_COMPUTE, 8'hFF);
    // Unused code must leave nothing behind
    push_item(ACT_UNUSED, 8'hFF);
    // Extreme bytes; shared run FF 55 at A[1], B[1]
    push_item(ACT_LOAD_A, 8'h00);
    push_item(ACT_LOAD_A, 8'hFF);
    push_item(ACT_LOAD_A, 8'h55);
    push_item(ACT_LOAD_B, 8'hAA);
    push_item(ACT_LOAD_B, 8'hFF);
    push_item(ACT_LOAD_B, 8'h55);
    push_item(ACT_COMPUTE, 8'h00);
    // Only A loaded: empty B gives zero
    push_item(ACT_LOAD_A, 8'h12);
    push_item(ACT_COMPUTE, 8'h00);
    // Nothing in common: zero length with zero starts
    push_item(ACT_LOAD_A, 8'h01);
    push_item(ACT_LOAD_B, 8'h02);
    push_item(ACT_COMPUTE, 8'h00);
    // Tie of single-byte matches: first in row-major order wins
    push_item(ACT_LOAD_A, 8'h41);
    push_item(ACT_LOAD_A, 8'h42);
    push_item(ACT_LOAD_B, 8'h42);
    push_item(ACT_LOAD_B, 8'h41);
    push_item(ACT_COMPUTE, 8'h00);
  endtask

  // One phase: registers (while idle), stall mix, then random jobs
  task automatic run_phase(input bit set_regs, input logic [16:0] lim, input logic [7:0] pat,
                           input int snd, input int rcv, input int unsigned target,
                           input int unsigned long_a, input int unsigned long_b);
    int unsigned start;
    if (set_regs) begin
      wait_idle();
      write_reg(REG_COMPLEXITY_LIMIT, lim);
      write_reg(REG_PATIENCE_ROWS, {9'd0, pat});
    end
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    start = pushed_count;
    if (long_a != 0 || long_b != 0)
      queue_long_run(long_a, long_b);
    while (pushed_count - start < target) begin
      queue_job();
      // Now and then hold the sender until the block has drained
      if ($urandom_range(0, 19) == 0)
        wait_idle();
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values first, with the directed cases
    snd_idle_pct = 28;
    rcv_idle_pct = 59;
    queue_directed();
    run_phase(1'b0, 17'd0, 8'd0, 28, 59, 150, 0, 0);
    // Largest limit, zero patience: scan stops after the first row
    run_phase(1'b1, 17'd131071, 8'd0, 28, 59, 150, 0, 0);
    // Zero limit forces suffix matching; overflow string A
    run_phase(1'b1, 17'd0, 8'd255, 59, 28, 100, 260, 3);
    // Small limit mixes both modes
    run_phase(1'b1, 17'd40, 8'd1, 59, 28, 150, 0, 0);
    // Limit exactly at full capacity: 256 x 256 scan, B overflows
    run_phase(1'b1, 17'd65536, 8'd3, 0, 0, 40, 256, 258);
    run_phase(1'b1, 17'd300, 8'd255, 0, 0, 280, 0, 0);
    wait_idle();

    $display("Run covered %0d items and %0d matches: %0d table, %0d suffix, %0d empty",
             accepted_count, checked_count, n_table, n_suffix, n_empty);
    $display("%0d matches carried the drop flag; %0d mismatches seen",
             n_dropped, error_count);
    if (error_count == 0 && expected_matches.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/lcsf_pkg.sv
sv/lcsf_ram.sv
sv/lcsf_ctrl.sv
sv/lcsf_dpath.sv
sv/longest_common_substring_finder_unit.sv
sim/longest_common_substring_finder_unit_tb.sv
